// ----- hw/rtl/hks_pkg.sv -----
// ----------------------------------------------------------------------------
// hks_pkg: shared types and constants of the hashed key set
// Field widths, table geometry, operation codes and the beat types that
// travel between the front end, the back end and the ports.
// ----------------------------------------------------------------------------
package hks_pkg;

  // Port field widths.
  localparam int KEY_W = 64;
  localparam int OP_W  = 2;

  // Table geometry.
  localparam int KEY_BYTES = 8;
  localparam int KEY_BITS  = 8 * KEY_BYTES;
  localparam int BUCKETS   = 256;
  localparam int BKT_W     = $clog2(BUCKETS);
  localparam int WAYS      = 4;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Depth of the request queue and of the result queue (a power of two).
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

  // Input beat as it appears on the ports.
  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
  } in_item_t;

  // Result beat as it appears on the ports.
  typedef struct packed {
    logic found;
    logic overflow;
  } out_item_t;

  // Classified request: normalized operation, masked key and its bucket.
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KEY_BITS-1:0] key;
    logic [BKT_W-1:0]    bucket;
  } req_t;

  // Request channel from the front end to the back end.
  typedef struct packed {
    logic valid;
    req_t req;
  } req_beat_t;

  // One table row: all ways of one bucket.
  typedef struct packed {
    logic [WAYS-1:0]                valid;
    logic [WAYS-1:0][KEY_BITS-1:0]  keys;
  } row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

// ----- hw/rtl/hks_ram.sv -----
// ----------------------------------------------------------------------------
// hks_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/hks_front.sv -----
// ----------------------------------------------------------------------------
// hks_front: request intake and classification
// Masks the key, hashes it to a bucket, normalizes the operation and holds
// classified requests in a short queue for the back end.
// ----------------------------------------------------------------------------
module hks_front import hks_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  input  logic      clearing,
  output req_beat_t req_beat,
  input  logic      req_pop
);

  logic [KEY_BITS-1:0] key_m;
  logic [BKT_W-1:0]    bucket;
  logic [OP_W-1:0]     op_n;
  req_t                req_new;
  logic                q_push;
  logic                q_pop;

  req_t                q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [Q_PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [Q_CNT_W-1:0]  cnt_r, cnt_nxt;

  // Bucket is the byte sum of the masked key, kept to its low bits.
  always_comb begin
    key_m  = in_item.key[KEY_BITS-1:0];
    bucket = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      bucket = bucket + BKT_W'(key_m[8*i +: 8]);
    end
  end

  // Unused operation codes behave as a check.
  always_comb begin
    case (in_item.operation)
      OP_ADD:    op_n = OP_ADD;
      OP_REMOVE: op_n = OP_REMOVE;
      default:   op_n = OP_CHECK;
    endcase
  end

  assign req_new = '{op: op_n, key: key_m, bucket: bucket};

  // Intake is closed while the table is being cleared.
  assign in_full = (cnt_r == Q_CNT_W'(Q_DEPTH)) || clearing;
  assign q_push  = in_push && !in_full;
  assign q_pop   = req_pop && (cnt_r != '0);

  // Queue pointers and fill count.
  always_comb begin
    wptr_nxt = q_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = q_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (q_push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!q_push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (q_push) begin
      q_r[wptr_r] <= req_new;
    end
  end

  assign req_beat = '{valid: (cnt_r != '0), req: q_r[rptr_r]};

endmodule

// ----- hw/rtl/hks_back.sv -----
// ----------------------------------------------------------------------------
// hks_back: table lookup and update
// Clears the bucket table after reset, then serves one request at a time:
// read the bucket row, compare all ways, write the row back and queue the
// result beat.
// ----------------------------------------------------------------------------
module hks_back import hks_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  req_beat_t req_beat,
  output logic      req_pop,
  output logic      clearing,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]          st_r, st_nxt;
  logic [BKT_W-1:0]    clr_r, clr_nxt;
  req_t                cur_r;

  logic                ram_we;
  logic [BKT_W-1:0]    ram_waddr;
  logic [ROW_W-1:0]    ram_wdata;
  logic [ROW_W-1:0]    ram_rdata;

  row_t                row;
  row_t                new_row;
  logic [WAYS-1:0]     hit;
  logic                lk_found;
  logic                lk_free;
  logic [WAY_W-1:0]    match_idx;
  logic [WAY_W-1:0]    free_idx;
  logic                lk_we;
  logic                lk_ovf;
  logic                res_push;
  out_item_t           res_new;

  out_item_t           oq_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  owptr_r, orptr_r;
  logic [Q_CNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic                res_pop;

  // Start a request only when the result queue has room for its beat.
  assign req_pop  = (st_r == ST_IDLE) && req_beat.valid && (ocnt_r != Q_CNT_W'(Q_DEPTH));
  assign clearing = (st_r == ST_CLEAR);
  assign res_push = (st_r == ST_LOOK);

  // Sequencer: clearing pass, then read and update per request.
  always_comb begin
    st_nxt  = st_r;
    clr_nxt = clr_r;
    case (st_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BKT_W'(BUCKETS - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_pop) begin
          st_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        st_nxt = ST_IDLE;
      end
      default: begin
        st_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLEAR;
      clr_r <= '0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
    end
  end

  // Hold the request under lookup.
  always_ff @(posedge clk) begin
    if (req_pop) begin
      cur_r <= req_beat.req;
    end
  end

  // Compare the ways of the row and pick the lowest match and free way.
  always_comb begin
    row       = row_t'(ram_rdata);
    match_idx = '0;
    free_idx  = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = row.valid[w] && (row.keys[w] == cur_r.key);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        match_idx = WAY_W'(w);
      end
      if (!row.valid[w]) begin
        free_idx = WAY_W'(w);
      end
    end
    lk_found = |hit;
    lk_free  = ~&row.valid;
  end

  // Update the row according to the operation.
  always_comb begin
    new_row = row;
    lk_we   = 1'b0;
    lk_ovf  = 1'b0;
    case (cur_r.op)
      OP_ADD: begin
        if (lk_free) begin
          new_row.valid[free_idx] = 1'b1;
          new_row.keys[free_idx]  = cur_r.key;
          lk_we                   = 1'b1;
        end else begin
          lk_ovf = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (lk_found) begin
          new_row.valid[match_idx] = 1'b0;
          lk_we                    = 1'b1;
        end
      end
      default: begin
        lk_we = 1'b0;
      end
    endcase
  end

  assign res_new = '{found: lk_found, overflow: lk_ovf};

  // Table write port: zero rows while clearing, updated row after a lookup.
  always_comb begin
    if (st_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = res_push && lk_we;
      ram_waddr = cur_r.bucket;
      ram_wdata = ROW_W'(new_row);
    end
  end

  hks_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (req_pop),
    .raddr (req_beat.req.bucket),
    .rdata (ram_rdata)
  );

  // Result queue.
  assign res_pop = out_pop && (ocnt_r != '0);

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (res_push && !res_pop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (!res_push && res_pop) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= '0;
      orptr_r <= '0;
      ocnt_r  <= '0;
    end else begin
      owptr_r <= res_push ? owptr_r + 1'b1 : owptr_r;
      orptr_r <= res_pop ? orptr_r + 1'b1 : orptr_r;
      ocnt_r  <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq_r[owptr_r] <= res_new;
    end
  end

  assign out_empty = (ocnt_r == '0);
  assign out_item  = oq_r[orptr_r];

endmodule

// ----- hw/rtl/hashed_key_set.sv -----
// ----------------------------------------------------------------------------
// hashed_key_set: bucketed set of access keys
// Adds, removes or checks keys in a 256-bucket table with a fixed number of
// ways per bucket, one result beat per request.
// ----------------------------------------------------------------------------
// After reset the block clears its table, one bucket row per cycle, and holds
// in_full high until that is done. Each request then goes through the back end
// in order: it reads its bucket row from the table RAM, then compares all ways
// and writes the row back; no new request starts before that is done.
// The front end hashes incoming beats and queues up to two of them; up to two
// result beats wait on the output queue.
// An add into a full bucket is dropped and reports overflow; duplicate keys
// may be stored and each remove frees one copy.
module hashed_key_set import hks_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  req_beat_t req_beat;
  logic      req_pop;
  logic      clearing;

  hks_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .clearing (clearing),
    .req_beat (req_beat),
    .req_pop  (req_pop)
  );

  hks_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_beat  (req_beat),
    .req_pop   (req_pop),
    .clearing  (clearing),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // Reset closes intake for the clearing pass and empties the result queue.
  a_reset_state: assert property (@(posedge clk) !rst_n |=> (in_full && out_empty))
    else $error("intake open or results pending right after reset");

  // The back end only takes a request that the front end offers.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    req_pop |-> req_beat.valid)
    else $error("request taken from an empty queue");

  // No beat is accepted while the table is being cleared.
  a_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (in_full && !req_pop))
    else $error("request activity during the clearing pass");

endmodule
